@@ rtl/rwr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_pkg - shared types and constants of the random walk rms block
// Field widths, opcodes, the queue entry layout and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package rwr_pkg;

  // field widths
  localparam int STEP_W  = 16;
  localparam int ANGLE_W = 9;
  localparam int PART_W  = 7;
  localparam int OFS_W   = 24;
  localparam int RMS_W   = 25;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 56;

  // defaults for the top-level parameters
  localparam int DEF_PARTICLES     = 128;
  localparam int DEF_FRACTION_BITS = 12;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;

  // opcodes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_MOVE    = 1'b1;

  // angles in degrees
  localparam int QUARTER_DEG = 90;
  localparam int HALF_DEG    = 180;
  localparam int THREEQ_DEG  = 270;
  localparam int TURN_DEG    = 360;

  // sine ROM: round(sin(d) * 2^16), d = 0..90
  localparam int ROM_W        = 17;
  localparam int ROM_FRAC     = 16;
  localparam int TRIG_ENTRIES = 91;
  localparam int TRIG_IDX_W   = 7;

  localparam int OFS_MAX = 8388607;
  localparam int OFS_MIN = -8388608;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [ROM_W-1:0] SIN_TABLE [TRIG_ENTRIES] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
    17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
    17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
    17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
    17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
    17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
    17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
    17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
    17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
    17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
    17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
    17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
    17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
    17'd65536
  };

  // decoded item, as it sits in the queue
  typedef struct packed {
    logic                  op;
    logic [TRIG_IDX_W-1:0] cos_idx;
    logic                  cos_neg;
    logic [TRIG_IDX_W-1:0] sin_idx;
    logic                  sin_neg;
  } cmd_t;

  function automatic logic [ROM_W-1:0] sin_rom(input logic [TRIG_IDX_W-1:0] idx);
    return (idx > TRIG_IDX_W'(QUARTER_DEG)) ? SIN_TABLE[QUARTER_DEG] : SIN_TABLE[idx];
  endfunction

endpackage

@@ rtl/random_walk_rms_step_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_rms_step_top - 2-D random walk with per-round rms distance
// Input beats (in_valid/in_ready) carry an opcode and an angle: a restart
// beat returns every particle to the centre, a move beat steps the next
// particle in turn. Each input beat yields one output beat
// (out_valid/out_ready) with the particle index, its new offsets, and the
// round flag, rms distance and round count. step_length is written through
// the APB port at address 0; the user must write it only while the block
// is idle, as the block itself does not enforce this. Each move passes through
// the read/multiply/add/square/accumulate sequence around the offset RAM,
// and no new item is taken until it is done; a restart result is registered
// as the restart is taken. A round's last move also runs a divide by the
// particle count (one byte per cycle), a square root and a handoff.
// A two-entry queue sits between decode and the engine, and the result sits
// in an output register, so a stalled receiver backs up into the queue and
// then into in_ready. Reset (rst_n, synchronous) empties the walk and sets
// step_length to 1.0; no clearing pass is needed since unwritten RAM entries
// read as zero until the first round completes.
// ----------------------------------------------------------------------------
module random_walk_rms_step_top
  import rwr_pkg::*;
#(
  parameter int PARTICLES     = DEF_PARTICLES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [ANGLE_W-1:0]      in_angle_deg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PART_W-1:0]       out_particle,
  output logic signed [OFS_W-1:0] out_x_offset,
  output logic signed [OFS_W-1:0] out_y_offset,
  output logic                    out_round_done,
  output logic [RMS_W-1:0]        out_rms_distance,
  output logic [CNT_W-1:0]        out_round_count,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd;
  logic              root_start;
  logic [SUM_W-1:0]  root_dividend;
  logic              root_done;
  logic [RMS_W-1:0]  root_rms;
  logic [STEP_W-1:0] step_length_r;
  logic              reg_sel;
  logic              cfg_wr;

  // word address; anything past the register list reads zero
  assign reg_sel = 1'(paddr >> 2);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == REG_STEP_LENGTH) ? CFG_DATA_W'(step_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= STEP_RESET;
    end else if (cfg_wr && (reg_sel == REG_STEP_LENGTH)) begin
      step_length_r <= pwdata[STEP_W-1:0];
    end
  end

  rwr_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_angle_deg (in_angle_deg),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  rwr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  rwr_root #(
    .PARTICLES (PARTICLES)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (root_dividend),
    .done     (root_done),
    .rms      (root_rms)
  );

  rwr_back #(
    .PARTICLES     (PARTICLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .step_length      (step_length_r),
    .root_start       (root_start),
    .root_dividend    (root_dividend),
    .root_done        (root_done),
    .root_rms         (root_rms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_particle     (out_particle),
    .out_x_offset     (out_x_offset),
    .out_y_offset     (out_y_offset),
    .out_round_done   (out_round_done),
    .out_rms_distance (out_rms_distance),
    .out_round_count  (out_round_count)
  );

endmodule

@@ rtl/rwr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_front - input decode
// Reduces the angle modulo 360 and folds it into a quadrant: ROM indexes and
// signs for cosine and sine, pushed to the queue with the opcode.
// ----------------------------------------------------------------------------
module rwr_front
  import rwr_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [ANGLE_W-1:0] in_angle_deg,
  output logic               push_valid,
  input  logic               push_ready,
  output cmd_t               push_cmd
);

  logic [ANGLE_W-1:0] ang;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    if (in_angle_deg >= ANGLE_W'(TURN_DEG)) begin
      ang = in_angle_deg - ANGLE_W'(TURN_DEG);
    end else begin
      ang = in_angle_deg;
    end
  end

  always_comb begin
    push_cmd.op = in_op;
    priority if (ang <= ANGLE_W'(QUARTER_DEG)) begin
      push_cmd.cos_idx = TRIG_IDX_W'(ANGLE_W'(QUARTER_DEG) - ang);
      push_cmd.cos_neg = 1'b0;
      push_cmd.sin_idx = TRIG_IDX_W'(ang);
      push_cmd.sin_neg = 1'b0;
    end else if (ang <= ANGLE_W'(HALF_DEG)) begin
      push_cmd.cos_idx = TRIG_IDX_W'(ang - ANGLE_W'(QUARTER_DEG));
      push_cmd.cos_neg = 1'b1;
      push_cmd.sin_idx = TRIG_IDX_W'(ANGLE_W'(HALF_DEG) - ang);
      push_cmd.sin_neg = 1'b0;
    end else if (ang <= ANGLE_W'(THREEQ_DEG)) begin
      push_cmd.cos_idx = TRIG_IDX_W'(ANGLE_W'(THREEQ_DEG) - ang);
      push_cmd.cos_neg = 1'b1;
      push_cmd.sin_idx = TRIG_IDX_W'(ang - ANGLE_W'(HALF_DEG));
      push_cmd.sin_neg = 1'b1;
    end else begin
      push_cmd.cos_idx = TRIG_IDX_W'(ang - ANGLE_W'(THREEQ_DEG));
      push_cmd.cos_neg = 1'b0;
      push_cmd.sin_idx = TRIG_IDX_W'(ANGLE_W'(TURN_DEG) - ang);
      push_cmd.sin_neg = 1'b1;
    end
  end

endmodule

@@ rtl/rwr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_queue - command queue
// Small FIFO of decoded items between the front decode and the back engine.
// ----------------------------------------------------------------------------
module rwr_queue
  import rwr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push_en;
  logic              pop_en;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_en    = push_valid && push_ready;
  assign pop_en     = pop && pop_valid;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_en) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_en && !pop_en) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop_en && !push_en) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && !pop_en) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule

@@ rtl/rwr_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_root - mean and square root unit
// Divides the square sum by the particle count one byte per cycle with a
// reciprocal multiply, then a two-bits-per-step integer square root on the
// quotient, saturated to 25 bits.
// ----------------------------------------------------------------------------
module rwr_root
  import rwr_pkg::*;
#(
  parameter int PARTICLES = DEF_PARTICLES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic             done,
  output logic [RMS_W-1:0] rms
);

  localparam int DIG_W   = 8;
  localparam int DIGITS  = SUM_W / DIG_W;
  localparam int CLOG_P  = $clog2(PARTICLES);
  localparam int REM_W   = (CLOG_P > 0) ? CLOG_P : 1;
  localparam int DIV_N   = REM_W + DIG_W;
  localparam int DIV_K   = DIV_N + CLOG_P;
  localparam int RCP_W   = DIV_N + 1;
  localparam int PRD_W   = DIV_N + RCP_W;
  localparam int STEP_CW = $clog2(DIGITS);
  // ceil(2^K / P): exact quotient for every chunk below 2^DIV_N
  localparam longint RCP_VAL =
    ((longint'(1) << DIV_K) + longint'(PARTICLES) - longint'(1)) / longint'(PARTICLES);
  localparam logic [RCP_W-1:0]   RECIP    = RCP_W'(RCP_VAL);
  localparam logic [DIV_N-1:0]   DIVISOR  = DIV_N'(PARTICLES);
  localparam logic [STEP_CW-1:0] DIV_LAST = STEP_CW'(DIGITS - 1);
  localparam logic [SUM_W-1:0]   SQRT_TOP = SUM_W'(1) << (SUM_W - 2);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_SQRT = 4'b0100,
    R_DONE = 4'b1000
  } root_state_t;

  root_state_t        state_r;
  root_state_t        state_nxt;
  logic [STEP_CW-1:0] cnt_r;
  logic [REM_W-1:0]   rem_r;
  logic [SUM_W-1:0]   quo_r;   // dividend/quotient, then the sqrt radicand
  logic [SUM_W-1:0]   res_r;
  logic [SUM_W-1:0]   bit_r;

  logic [DIV_N-1:0]   chunk;
  logic [PRD_W-1:0]   prd;
  logic [DIG_W-1:0]   qdig;
  logic [REM_W-1:0]   rem_step;
  logic [SUM_W-1:0]   quo_step;
  logic [SUM_W-1:0]   cand;
  logic               fits;

  always_comb begin
    chunk    = {rem_r, quo_r[SUM_W-1 -: DIG_W]};
    prd      = PRD_W'(chunk) * PRD_W'(RECIP);
    qdig     = DIG_W'(prd >> DIV_K);
    rem_step = REM_W'(chunk - DIV_N'(qdig) * DIVISOR);
    quo_step = {quo_r[SUM_W-DIG_W-1:0], qdig};
    cand     = res_r + bit_r;
    fits     = (quo_r >= cand);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE: begin
        if (start) state_nxt = R_DIV;
      end
      R_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = R_SQRT;
      end
      R_SQRT: begin
        if (bit_r[0]) state_nxt = R_DONE;
      end
      R_DONE: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == R_IDLE) begin
        cnt_r <= '0;
      end else if (state_r == R_DIV) begin
        cnt_r <= cnt_r + STEP_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          quo_r <= dividend;
          rem_r <= '0;
        end
      end
      R_DIV: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        if (cnt_r == DIV_LAST) begin
          res_r <= '0;
          bit_r <= SQRT_TOP;
        end
      end
      R_SQRT: begin
        if (fits) begin
          quo_r <= quo_r - cand;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == R_DONE);
  assign rms  = (|res_r[SUM_W-1:RMS_W]) ? '1 : res_r[RMS_W-1:0];

endmodule

@@ rtl/rwr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_back - walk engine
// Pops decoded items, updates the particle offsets held in a RAM, keeps the
// square sum and round count, hands round ends to the root unit and drives
// the result register.
// ----------------------------------------------------------------------------
module rwr_back
  import rwr_pkg::*;
#(
  parameter int PARTICLES     = DEF_PARTICLES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  input  logic [STEP_W-1:0]       step_length,
  output logic                    root_start,
  output logic [SUM_W-1:0]        root_dividend,
  input  logic                    root_done,
  input  logic [RMS_W-1:0]        root_rms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PART_W-1:0]       out_particle,
  output logic signed [OFS_W-1:0] out_x_offset,
  output logic signed [OFS_W-1:0] out_y_offset,
  output logic                    out_round_done,
  output logic [RMS_W-1:0]        out_rms_distance,
  output logic [CNT_W-1:0]        out_round_count
);

  localparam int IDX_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int MAG_W  = FRACTION_BITS + 1;
  localparam int RSH    = ROM_FRAC - FRACTION_BITS;
  localparam int RND    = (RSH > 0) ? (1 << (RSH - 1)) : 0;
  localparam int PROD_W = STEP_W + MAG_W;
  localparam int HALF   = 1 << (FRACTION_BITS - 1);
  localparam int DLT_W  = PROD_W + 1 - FRACTION_BITS;
  localparam int EXT_W  = ((DLT_W > OFS_W) ? DLT_W : OFS_W) + 2;
  localparam int SQ_W   = 2 * OFS_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLES - 1);
  localparam logic signed [EXT_W-1:0] EXT_MAX = EXT_W'(OFS_MAX);
  localparam logic signed [EXT_W-1:0] EXT_MIN = EXT_W'(OFS_MIN);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_MUL  = 7'b0000010,
    B_ADD  = 7'b0000100,
    B_SQ   = 7'b0001000,
    B_ACC  = 7'b0010000,
    B_ROOT = 7'b0100000,
    B_FIN  = 7'b1000000
  } back_state_t;

  function automatic logic [MAG_W-1:0] trig_mag(input logic [TRIG_IDX_W-1:0] idx);
    logic [ROM_W-1:0] raw;
    raw = sin_rom(idx) + ROM_W'(RND);
    return MAG_W'(raw >> RSH);
  endfunction

  // rounded step on the magnitude, signed add, clamp to the offset range
  function automatic logic signed [OFS_W-1:0] step_sat(
    input logic signed [OFS_W-1:0] pos,
    input logic [PROD_W-1:0]       prod,
    input logic                    neg
  );
    logic [PROD_W:0]          rnd;
    logic [DLT_W-1:0]         dlt;
    logic signed [EXT_W-1:0]  pos_x;
    logic signed [EXT_W-1:0]  dlt_x;
    logic signed [EXT_W-1:0]  tot;
    rnd   = {1'b0, prod} + (PROD_W + 1)'(HALF);
    dlt   = DLT_W'(rnd >> FRACTION_BITS);
    pos_x = EXT_W'(pos);
    dlt_x = $signed(EXT_W'(dlt));
    tot   = neg ? (pos_x - dlt_x) : (pos_x + dlt_x);
    if (tot > EXT_MAX) begin
      tot = EXT_MAX;
    end else if (tot < EXT_MIN) begin
      tot = EXT_MIN;
    end
    return OFS_W'(tot);
  endfunction

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic [IDX_W-1:0]         next_r;
  logic                     wrapped_r;   // a full round has passed since restart
  logic [CNT_W-1:0]         rounds_r;
  logic [RMS_W-1:0]         last_rms_r;
  logic [SUM_W-1:0]         sum_r;

  logic [2*OFS_W-1:0]       mem_q [PARTICLES];
  logic [2*OFS_W-1:0]       rd_r;

  logic [MAG_W-1:0]         cmag_r;
  logic [MAG_W-1:0]         smag_r;
  logic                     cneg_r;
  logic                     sneg_r;
  logic [PROD_W-1:0]        prodc_r;
  logic [PROD_W-1:0]        prods_r;
  logic signed [OFS_W-1:0]  oldx_r;
  logic signed [OFS_W-1:0]  oldy_r;
  logic signed [OFS_W-1:0]  nx_r;
  logic signed [OFS_W-1:0]  ny_r;
  logic [SQ_W-2:0]          xx_r;
  logic [SQ_W-2:0]          yy_r;

  logic signed [OFS_W-1:0]  nx_step;
  logic signed [OFS_W-1:0]  ny_step;
  logic signed [SQ_W-1:0]   sqx;
  logic signed [SQ_W-1:0]   sqy;
  logic [SUM_W:0]           acc_sum;
  logic [SUM_W-1:0]         sum_sat;

  logic                     out_valid_r;
  logic [PART_W-1:0]        out_particle_r;
  logic signed [OFS_W-1:0]  out_x_r;
  logic signed [OFS_W-1:0]  out_y_r;
  logic                     out_done_r;
  logic [RMS_W-1:0]         out_rms_r;
  logic [CNT_W-1:0]         out_count_r;

  logic out_free;
  logic is_last;
  logic take_restart;
  logic take_move;
  logic acc_end;
  logic acc_emit;
  logic fin_emit;
  logic out_load;

  assign out_free     = !out_valid_r || out_ready;
  assign is_last      = (next_r == LAST_IDX);
  assign take_restart = (state_r == B_IDLE) && q_valid && (q_cmd.op == OP_RESTART) && out_free;
  assign take_move    = (state_r == B_IDLE) && q_valid && (q_cmd.op == OP_MOVE);
  assign acc_end      = (state_r == B_ACC) && is_last;
  assign acc_emit     = (state_r == B_ACC) && !is_last && out_free;
  assign fin_emit     = (state_r == B_FIN) && out_free;
  assign out_load     = take_restart || acc_emit || fin_emit;
  assign q_pop        = take_restart || take_move;
  assign root_start   = acc_end;
  assign root_dividend = sum_sat;

  always_comb begin
    nx_step = step_sat(oldx_r, prodc_r, cneg_r);
    ny_step = step_sat(oldy_r, prods_r, sneg_r);
    sqx     = nx_r * nx_r;
    sqy     = ny_r * ny_r;
    acc_sum = {1'b0, sum_r} + (SUM_W + 1)'(xx_r) + (SUM_W + 1)'(yy_r);
    sum_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (take_move) state_nxt = B_MUL;
      end
      B_MUL: state_nxt = B_ADD;
      B_ADD: state_nxt = B_SQ;
      B_SQ:  state_nxt = B_ACC;
      B_ACC: begin
        if (acc_end) begin
          state_nxt = B_ROOT;
        end else if (acc_emit) begin
          state_nxt = B_IDLE;
        end
      end
      B_ROOT: begin
        if (root_done) state_nxt = B_FIN;
      end
      B_FIN: begin
        if (fin_emit) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // offset RAM: x in the upper half, y in the lower half
  always_ff @(posedge clk) begin
    if (state_r == B_ADD) begin
      mem_q[next_r] <= {nx_step, ny_step};
    end
    rd_r <= mem_q[next_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE) begin
      cmag_r <= trig_mag(q_cmd.cos_idx);
      smag_r <= trig_mag(q_cmd.sin_idx);
      cneg_r <= q_cmd.cos_neg;
      sneg_r <= q_cmd.sin_neg;
    end
    if (state_r == B_MUL) begin
      prodc_r <= PROD_W'(step_length) * PROD_W'(cmag_r);
      prods_r <= PROD_W'(step_length) * PROD_W'(smag_r);
      // until the first round after a restart completes, entries read as the centre
      oldx_r  <= wrapped_r ? rd_r[2*OFS_W-1:OFS_W] : '0;
      oldy_r  <= wrapped_r ? rd_r[OFS_W-1:0] : '0;
    end
    if (state_r == B_ADD) begin
      nx_r <= nx_step;
      ny_r <= ny_step;
    end
    if (state_r == B_SQ) begin
      xx_r <= sqx[SQ_W-2:0];
      yy_r <= sqy[SQ_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      next_r     <= '0;
      wrapped_r  <= 1'b0;
      rounds_r   <= '0;
      last_rms_r <= '0;
      sum_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (take_restart) begin
        next_r     <= '0;
        wrapped_r  <= 1'b0;
        rounds_r   <= '0;
        last_rms_r <= '0;
        sum_r      <= '0;
      end
      if (acc_emit) begin
        sum_r  <= sum_sat;
        next_r <= next_r + IDX_W'(1);
      end
      if (acc_end) begin
        sum_r <= '0;
      end
      if ((state_r == B_ROOT) && root_done) begin
        last_rms_r <= root_rms;
        rounds_r   <= rounds_r + CNT_W'(1);
        wrapped_r  <= 1'b1;
      end
      if (fin_emit) begin
        next_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_particle_r <= take_restart ? '0 : PART_W'(next_r);
      out_x_r        <= take_restart ? '0 : nx_r;
      out_y_r        <= take_restart ? '0 : ny_r;
      out_done_r     <= fin_emit;
      out_rms_r      <= take_restart ? '0 : last_rms_r;
      out_count_r    <= take_restart ? '0 : rounds_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_particle     = out_particle_r;
  assign out_x_offset     = out_x_r;
  assign out_y_offset     = out_y_r;
  assign out_round_done   = out_done_r;
  assign out_rms_distance = out_rms_r;
  assign out_round_count  = out_count_r;

`ifndef NO_ASSERTIONS
  a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= LAST_IDX)
    else $error("particle index past the last particle");

  a_round_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_particle_r == PART_W'(PARTICLES - 1)))
    else $error("round end on a particle other than the last");

  a_root_kick: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |=> (state_r == B_ROOT) && (sum_r == '0))
    else $error("root start without clearing the sum");
`endif

endmodule

@@ test/random_walk_rms_step_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_rms_step_top_test - self-checking bench for the random walk block
// Drives opcode/angle beats with random gaps and output back-pressure, predicts
// every result beat (offsets, round flag, rms, round count) with an in-bench
// model of the walk, and checks the step_length register through the APB port.
// A short opening sequence is followed by random walks at several step
// lengths and rounds with a fixed direction per particle at the widest step.
// ----------------------------------------------------------------------------
module random_walk_rms_step_top_test;
  import rwr_pkg::*;

  localparam int WALKERS     = DEF_PARTICLES;
  localparam int FRAC        = DEF_FRACTION_BITS;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int END_SETTLE  = 120;
  localparam int SAT_ROUNDS  = 2;
  localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] RMS_MAX = (64'd1 << RMS_W) - 64'd1;
  localparam logic [CFG_ADDR_W-1:0] STEP_ADDR = CFG_ADDR_W'(4 * int'(REG_STEP_LENGTH));

  typedef struct {
    logic [PART_W-1:0]       particle;
    logic signed [OFS_W-1:0] x_ofs;
    logic signed [OFS_W-1:0] y_ofs;
    logic                    round_done;
    logic [RMS_W-1:0]        rms;
    logic [CNT_W-1:0]        count;
  } walk_result_t;

  typedef struct {
    logic               op;
    logic [ANGLE_W-1:0] angle;
    bit                 typed;
    int                 particle;
    int                 x_ofs;
    int                 y_ofs;
  } opening_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_op = OP_MOVE;
  logic [ANGLE_W-1:0]      in_angle_deg = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PART_W-1:0]       out_particle;
  logic signed [OFS_W-1:0] out_x_offset;
  logic signed [OFS_W-1:0] out_y_offset;
  logic                    out_round_done;
  logic [RMS_W-1:0]        out_rms_distance;
  logic [CNT_W-1:0]        out_round_count;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  random_walk_rms_step_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_angle_deg    (in_angle_deg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_particle    (out_particle),
    .out_x_offset    (out_x_offset),
    .out_y_offset    (out_y_offset),
    .out_round_done  (out_round_done),
    .out_rms_distance(out_rms_distance),
    .out_round_count (out_round_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // walk model state
  logic [STEP_W-1:0]       walk_step_len;
  logic signed [OFS_W-1:0] walk_x [WALKERS];
  logic signed [OFS_W-1:0] walk_y [WALKERS];
  logic [63:0]             walk_sum;
  int                      walk_next;
  logic [CNT_W-1:0]        walk_rounds;
  logic [63:0]             walk_rms;

  walk_result_t pending_walk_results[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  tx_calm_left = 0;
  int  rx_calm_left = 0;
  int  rx_hold_left = 0;
  bit  steady = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;

  opening_row_t opening_rows [24] = '{
    '{OP_MOVE,    9'd0,   1'b1, 0, 4096,  0},
    '{OP_MOVE,    9'd90,  1'b1, 1, 0,     4096},
    '{OP_MOVE,    9'd180, 1'b1, 2, -4096, 0},
    '{OP_MOVE,    9'd270, 1'b1, 3, 0,     -4096},
    '{OP_MOVE,    9'd360, 1'b1, 4, 4096,  0},
    '{OP_MOVE,    9'd511, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd359, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd45,  1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd256, 1'b0, 0, 0,     0},
    '{OP_RESTART, 9'd0,   1'b1, 0, 0,     0},
    '{OP_RESTART, 9'd511, 1'b1, 0, 0,     0},
    '{OP_MOVE,    9'd0,   1'b1, 0, 4096,  0},
    '{OP_MOVE,    9'd1,   1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd89,  1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd91,  1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd135, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd179, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd181, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd225, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd269, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd271, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd315, 1'b0, 0, 0,     0},
    '{OP_MOVE,    9'd361, 1'b0, 0, 0,     0},
    '{OP_RESTART, 9'd256, 1'b1, 0, 0,     0}
  };

  function automatic int trig_mag(int idx);
    int v;
    v = SIN_TABLE[idx > QUARTER_DEG ? QUARTER_DEG : idx];
    return (v + (1 << (ROM_FRAC - FRAC - 1))) >> (ROM_FRAC - FRAC);
  endfunction

  function automatic logic signed [OFS_W-1:0] step_offset(logic signed [OFS_W-1:0] pos,
                                                          int mag, bit neg);
    longint delta;
    longint moved;
    delta = (longint'(walk_step_len) * longint'(mag) + (longint'(1) << (FRAC - 1))) >>> FRAC;
    moved = longint'(pos) + (neg ? -delta : delta);
    if (moved > OFS_MAX) moved = OFS_MAX;
    if (moved < OFS_MIN) moved = OFS_MIN;
    return OFS_W'(moved);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_walk();
    foreach (walk_x[i]) begin
      walk_x[i] = '0;
      walk_y[i] = '0;
    end
    walk_sum    = '0;
    walk_next   = 0;
    walk_rounds = '0;
    walk_rms    = '0;
  endfunction

  function automatic walk_result_t predict_walk_step(logic op, logic [ANGLE_W-1:0] angle);
    walk_result_t r;
    int a, cidx, sidx, p;
    bit cneg, sneg;
    longint sx, sy;
    logic [63:0] sq;
    r = '{default: '0};
    if (op == OP_RESTART) begin
      clear_walk();
      return r;
    end
    a = int'(angle) % TURN_DEG;
    if (a <= QUARTER_DEG) begin
      cidx = QUARTER_DEG - a; cneg = 1'b0; sidx = a;            sneg = 1'b0;
    end else if (a <= HALF_DEG) begin
      cidx = a - QUARTER_DEG; cneg = 1'b1; sidx = HALF_DEG - a; sneg = 1'b0;
    end else if (a <= THREEQ_DEG) begin
      cidx = THREEQ_DEG - a;  cneg = 1'b1; sidx = a - HALF_DEG; sneg = 1'b1;
    end else begin
      cidx = a - THREEQ_DEG;  cneg = 1'b0; sidx = TURN_DEG - a; sneg = 1'b1;
    end
    p = (walk_next >= WALKERS) ? 0 : walk_next;
    walk_x[p] = step_offset(walk_x[p], trig_mag(cidx), cneg);
    walk_y[p] = step_offset(walk_y[p], trig_mag(sidx), sneg);
    sx = walk_x[p];
    sy = walk_y[p];
    sq = 64'(sx * sx + sy * sy);
    walk_sum = (SUM_MAX - walk_sum < sq) ? SUM_MAX : walk_sum + sq;
    if (p + 1 >= WALKERS) begin
      walk_rms = floor_sqrt(walk_sum / WALKERS);
      if (walk_rms > RMS_MAX) walk_rms = RMS_MAX;
      walk_sum = '0;
      walk_rounds = walk_rounds + 1'b1;
      walk_next = 0;
      r.round_done = 1'b1;
    end else begin
      walk_next = p + 1;
    end
    r.particle = PART_W'(p);
    r.x_ofs    = walk_x[p];
    r.y_ofs    = walk_y[p];
    r.rms      = walk_rms[RMS_W-1:0];
    r.count    = walk_rounds;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // one APB transfer, then a cycle with psel low
  task automatic apb_access(bit write, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= STEP_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_step_reg(logic [STEP_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(value))
      report_mismatch($sformatf("step_length readback got %0h want %0h", rd, value));
  endtask

  // stop sending and wait until every pending result has been taken
  task automatic drain_walk();
    in_valid <= 1'b0;
    while (pending_walk_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_step(logic [STEP_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    drain_walk();
    apb_access(1'b1, CFG_DATA_W'(value), rd);
    walk_step_len = value;
    check_step_reg(value);
  endtask

  // valid stays up across back-to-back beats; gaps only drop it here
  task automatic send_beat(logic op, logic [ANGLE_W-1:0] angle, bit typed,
                           walk_result_t typed_res);
    walk_result_t predicted;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_angle_deg <= angle;
    do @(posedge clk); while (!in_ready);
    predicted = predict_walk_step(op, angle);
    pending_walk_results.push_back(typed ? typed_res : predicted);
    if (!steady) begin
      if (tx_calm_left > 0) begin
        tx_calm_left--;
      end else if ($urandom_range(0, 29) == 0) begin
        tx_calm_left = $urandom_range(20, 80);
      end else if ($urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic run_random_walk(int n_items, int pause_at);
    walk_result_t unused;
    logic op;
    logic [ANGLE_W-1:0] angle;
    unused = '{default: '0};
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain_walk();
      op = ($urandom_range(0, 299) == 0) ? OP_RESTART : OP_MOVE;
      angle = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom_range(0, 511))
                                          : ANGLE_W'($urandom_range(0, TURN_DEG - 1));
      send_beat(op, angle, 1'b0, unused);
    end
  endtask

  // result side: compare each beat against the oldest prediction
  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_walk_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, particle %0d",
                                  out_particle));
      end else begin
        want = pending_walk_results.pop_front();
        if (out_particle !== want.particle)
          report_mismatch($sformatf("particle got %0d want %0d", out_particle, want.particle));
        if (out_x_offset !== want.x_ofs)
          report_mismatch($sformatf("x_offset got %0d want %0d", out_x_offset, want.x_ofs));
        if (out_y_offset !== want.y_ofs)
          report_mismatch($sformatf("y_offset got %0d want %0d", out_y_offset, want.y_ofs));
        if (out_round_done !== want.round_done)
          report_mismatch($sformatf("round_done got %0b want %0b", out_round_done,
                                    want.round_done));
        if (out_rms_distance !== want.rms)
          report_mismatch($sformatf("rms_distance got %0d want %0d", out_rms_distance,
                                    want.rms));
        if (out_round_count !== want.count)
          report_mismatch($sformatf("round_count got %0d want %0d", out_round_count,
                                    want.count));
      end
    end
  end

  // receiver: short random stalls, calm stretches, one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_hold_left == 0) begin
        if (long_hold_req && !long_hold_done) begin
          long_hold_done = 1'b1;
          rx_hold_left = LONG_HOLD;
        end else if (!steady) begin
          if (rx_calm_left > 0) rx_calm_left--;
          else if ($urandom_range(0, 39) == 0) rx_calm_left = $urandom_range(20, 80);
          else if ($urandom_range(0, 5) == 0) rx_hold_left = $urandom_range(1, 5);
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL random_walk_rms_step_top");
        $finish;
      end
    end
  end

  initial begin
    walk_result_t typed_res;
    walk_result_t unused;
    opening_row_t row;
    logic [ANGLE_W-1:0] sat_angle;
    unused = '{default: '0};
    walk_step_len = STEP_RESET;
    clear_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_step_reg(STEP_RESET);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      typed_res = '{default: '0};
      typed_res.particle = PART_W'(row.particle);
      typed_res.x_ofs    = OFS_W'(row.x_ofs);
      typed_res.y_ofs    = OFS_W'(row.y_ofs);
      send_beat(row.op, row.angle, row.typed, typed_res);
    end

    // widest step, with the receiver backing the block up at the start
    set_step('1);
    long_hold_req = 1'b1;
    run_random_walk(400, -1);

    set_step('0);
    run_random_walk(150, -1);

    // sender pauses mid-phase until the block has emptied
    set_step(STEP_W'($urandom_range(0, 65535)));
    run_random_walk(400, 200);

    // same direction per particle every round at the widest step
    set_step('1);
    send_beat(OP_RESTART, ANGLE_W'($urandom_range(0, 511)), 1'b0, unused);
    for (int k = 0; k < SAT_ROUNDS * WALKERS; k++) begin
      case (k % 4)
        0:       sat_angle = $urandom_range(0, 1) ? ANGLE_W'(0) : ANGLE_W'(TURN_DEG);
        1:       sat_angle = ANGLE_W'(QUARTER_DEG);
        2:       sat_angle = ANGLE_W'(HALF_DEG);
        default: sat_angle = ANGLE_W'(THREEQ_DEG);
      endcase
      send_beat(OP_MOVE, sat_angle, 1'b0, unused);
    end
    send_beat(OP_RESTART, ANGLE_W'($urandom_range(0, 511)), 1'b0, unused);

    set_step(STEP_W'(1));
    run_random_walk(150, -1);

    // closing stretch at full rate on both sides
    set_step(STEP_W'($urandom_range(0, 65535)));
    steady = 1'b1;
    run_random_walk(600, -1);

    drain_walk();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS random_walk_rms_step_top");
    end else begin
      $display("FAIL random_walk_rms_step_top");
    end
    $finish;
  end

endmodule
